>>> hdl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int unsigned PAGE_W    = 16;
  localparam int unsigned FRAME_W   = 3;
  localparam int unsigned FAULT_W   = 16;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam int unsigned S_TDATA_W = 16;  // page
  localparam int unsigned S_TUSER_W = 1;   // start_run
  localparam int unsigned M_TDATA_W = 40;  // frame, evicted_page, fault_count, pad
  localparam int unsigned M_TUSER_W = 2;   // hit, evicted_valid

  localparam logic [APB_AW-1:0] ADDR_FRAMES_IN_USE = 3'h0;
  localparam logic [CFG_W-1:0]  FRAMES_IN_USE_RST  = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  typedef struct packed {
    logic accept;  // new reference latched this cycle
    logic scan;    // walk the frame store
    logic commit;  // apply update and load the result register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

>>> hdl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement unit over a fully associative frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one page reference per transaction: tdata holds
//   the page number, tuser the start_run flag that empties all frames and
//   clears the fault count before the lookup.
//   Master stream returns one result per reference: tuser holds hit and
//   evicted_valid, tdata holds frame, evicted_page and fault_count.
//   APB register 0 (frames_in_use) limits how many frames may be filled;
//   0 acts as 1, values above FRAMES act as FRAMES. Write it while idle.
// Timing:
//   The store is scanned one frame per cycle. A miss scans every filled
//   frame before its result is loaded (none with an empty store); a hit
//   in frame j ends the scan once frame j matches. The next reference is
//   accepted only after the result is loaded: one reference at a time.
// Reset and stall:
//   Reset empties all frames, clears the fault count and sets
//   frames_in_use to 8. The result sits in an output register; while the
//   receiver stalls, a following reference is accepted and scanned, and
//   its commit waits until the register is free.
// ----------------------------------------------------------------------------
module lru_page_replacement import lru_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // reference stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [15:0] page
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // [0] start_run
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [2:0] frame, [18:3] evicted_page,
                                               // [34:19] fault_count, [39:35] zero
  output logic [M_TUSER_W-1:0] m_axis_tuser,   // [0] hit, [1] evicted_valid
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  cmd_t               cmd;
  status_t            status;
  logic [CFG_W-1:0]   frames_in_use_q;
  logic               res_hit, res_ev_valid;
  logic [FRAME_W-1:0] res_frame;
  logic [PAGE_W-1:0]  res_ev_page;
  logic [FAULT_W-1:0] res_fault;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_FRAMES_IN_USE)) begin
      frames_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_FRAMES_IN_USE) ? APB_DW'(frames_in_use_q) : '0;

  lru_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lru_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .page_i          (s_axis_tdata[PAGE_W-1:0]),
    .start_run_i     (s_axis_tuser[0]),
    .frames_in_use_i (frames_in_use_q),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_hit_o       (res_hit),
    .out_frame_o     (res_frame),
    .out_ev_valid_o  (res_ev_valid),
    .out_ev_page_o   (res_ev_page),
    .out_fault_o     (res_fault)
  );

  assign m_axis_tdata = {{(M_TDATA_W - FRAME_W - PAGE_W - FAULT_W){1'b0}},
                         res_fault, res_ev_page, res_frame};
  assign m_axis_tuser = {res_ev_valid, res_hit};

  // one reference in flight: no new transaction right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("reference accepted while one is still in work");

  // a commit never overwrites a result that has not been taken
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // an eviction only happens on a fault
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("eviction reported on a hit");

endmodule

>>> hdl/lru_ctrl.sv
// ----------------------------------------------------------------------------
// lru_ctrl
// Sequencer: accepts a reference, runs the store scan, commits the result.
// ----------------------------------------------------------------------------
module lru_ctrl import lru_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  output logic    s_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done && status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/lru_dp.sv
// ----------------------------------------------------------------------------
// lru_dp
// Frame store, recency ranks, fault counter and the result register.
// ----------------------------------------------------------------------------
module lru_dp import lru_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic               start_run_i,
  input  logic [CFG_W-1:0]   frames_in_use_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_hit_o,
  output logic [FRAME_W-1:0] out_frame_o,
  output logic               out_ev_valid_o,
  output logic [PAGE_W-1:0]  out_ev_page_o,
  output logic [FAULT_W-1:0] out_fault_o
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);

  logic [PAGE_BITS-1:0] mem_q [FRAMES];
  logic [IW-1:0]        rank_q [FRAMES];

  logic [CW-1:0]        filled_q, rd_cnt_q, limit;
  logic [FAULT_W-1:0]   fault_q, fault_next;
  logic [PAGE_BITS-1:0] page_q, rdata_q, lru_page_q;
  logic                 cmp_vld_q, hit_q, issue, fill, ev_valid, out_valid_q;
  logic [IW-1:0]        cmp_idx_q, hit_idx_q, hit_rank_q, lru_idx_q, tgt, r_ref;

  logic [PAGE_BITS+PAGE_W-1:0] page_wide;
  logic [PAGE_BITS+PAGE_W-1:0] ev_wide;
  logic [IW+FRAME_W-1:0]       frame_wide;

  // page bits above PAGE_BITS are dropped
  assign page_wide = {{PAGE_BITS{1'b0}}, page_i};

  // clamp the frame limit to 1..FRAMES
  always_comb begin
    if (frames_in_use_i == '0) begin
      limit = CW'(1);
    end else if (32'(frames_in_use_i) > FRAMES) begin
      limit = CW'(FRAMES);
    end else begin
      limit = CW'(frames_in_use_i);
    end
  end

  assign issue = cmd_i.scan && !hit_q && (rd_cnt_q < filled_q);

  assign status_o.scan_done = hit_q || ((rd_cnt_q == filled_q) && !cmp_vld_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // ranks form a permutation of 0..filled-1, so the LRU frame holds filled-1;
  // a fill ages every filled frame, which is a touch with reference = filled
  assign fill     = !hit_q && (filled_q < limit);
  assign ev_valid = !hit_q && !fill;
  assign tgt      = hit_q ? hit_idx_q : (fill ? filled_q[IW-1:0] : lru_idx_q);
  assign r_ref    = hit_q ? hit_rank_q
                  : (fill ? filled_q[IW-1:0] : IW'(filled_q - CW'(1)));

  assign fault_next = hit_q ? fault_q
                    : ((fault_q == '1) ? fault_q : fault_q + FAULT_W'(1));

  assign ev_wide    = {{PAGE_W{1'b0}}, lru_page_q};
  assign frame_wide = {{FRAME_W{1'b0}}, tgt};

  // frame store: one read port for the scan, one write port at commit
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q   <= mem_q[rd_cnt_q[IW-1:0]];
      cmp_idx_q <= rd_cnt_q[IW-1:0];
    end
    if (cmd_i.commit && !hit_q) begin
      mem_q[tgt] <= page_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q <= page_wide[PAGE_BITS-1:0];
    end
    if (cmp_vld_q && !hit_q) begin
      if (rdata_q == page_q) begin
        hit_idx_q  <= cmp_idx_q;
        hit_rank_q <= rank_q[cmp_idx_q];
      end
      if (rank_q[cmp_idx_q] == IW'(filled_q - CW'(1))) begin
        lru_idx_q  <= cmp_idx_q;
        lru_page_q <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      filled_q  <= '0;
      fault_q   <= '0;
    end else if (cmd_i.accept) begin
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      if (start_run_i) begin
        filled_q <= '0;
        fault_q  <= '0;
      end
    end else begin
      cmp_vld_q <= issue;
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end
      if (cmp_vld_q && !hit_q && (rdata_q == page_q)) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        fault_q <= fault_next;
        if (fill) begin
          filled_q <= filled_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.accept && start_run_i) begin
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (IW'(i) == tgt) begin
          rank_q[i] <= '0;
        end else if ((CW'(i) < filled_q) && (rank_q[i] < r_ref)) begin
          rank_q[i] <= rank_q[i] + IW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_o      <= hit_q;
      out_frame_o    <= frame_wide[FRAME_W-1:0];
      out_ev_valid_o <= ev_valid;
      out_ev_page_o  <= ev_valid ? ev_wide[PAGE_W-1:0] : '0;
      out_fault_o    <= fault_next;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
